// ===== rtl/bvflm_pkg.sv =====
package bvflm_pkg;

    // Millivolt fields and the fixed-point filter value.
    localparam int MV_W        = 13;
    localparam int FRAC_BITS   = 8;
    localparam int FILT_W      = MV_W + FRAC_BITS;

    // Gains are Q1.8, so one is 256 and the product is shifted down by eight.
    localparam int GAIN_W      = 9;
    localparam int GAIN_SHIFT  = 8;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_SHIFT);
    localparam int PROD_W      = FILT_W + GAIN_W;

    localparam int CNT_W       = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_REJECT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd4;

    localparam logic [GAIN_W-1:0] RISE_GAIN_RST     = 9'd77;
    localparam logic [GAIN_W-1:0] FALL_GAIN_RST     = 9'd13;
    localparam logic [MV_W-1:0]   DROP_REJECT_RST   = 13'd100;
    localparam logic [MV_W-1:0]   LOW_THRESHOLD_RST = 13'd900;
    localparam logic [CNT_W-1:0]  LOW_LIMIT_RST     = 8'd30;

    typedef struct packed {
        logic [GAIN_W-1:0] rise_gain_q8;
        logic [GAIN_W-1:0] fall_gain_q8;
        logic [MV_W-1:0]   drop_reject_mv;
        logic [MV_W-1:0]   low_threshold_mv;
        logic [CNT_W-1:0]  low_count_limit;
    } cfg_t;

    // Beat from the filter stage to the monitor stage.
    typedef struct packed {
        logic [MV_W-1:0] filtered_mv;
        logic            rejected;
        logic            check;     // regular update: run the low-voltage check
    } mid_t;

endpackage

// ===== rtl/bvflm_in_if.sv =====
interface bvflm_in_if import bvflm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] sample_mv;
    logic            external_power;

    modport source (output valid, output sample_mv, output external_power, input ready);
    modport sink   (input valid, input sample_mv, input external_power, output ready);
endinterface

// ===== rtl/bvflm_out_if.sv =====
interface bvflm_out_if import bvflm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  filtered_mv;
    logic             sample_rejected;
    logic [CNT_W-1:0] low_events;
    logic             sleep_request;

    modport source (output valid, output filtered_mv, output sample_rejected,
                    output low_events, output sleep_request, input ready);
    modport sink   (input valid, input filtered_mv, input sample_rejected,
                    input low_events, input sleep_request, output ready);
endinterface

// ===== rtl/bvflm_filter.sv =====
module bvflm_filter import bvflm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bvflm_in_if.sink   samples,
    input  cfg_t       cfg,
    output mid_t       mid,
    output logic       mid_valid,
    input  logic       mid_ready
);

    logic              in_valid_reg;
    logic [MV_W-1:0]   in_sample_reg;
    logic              in_ext_reg;

    logic [FILT_W-1:0] filter_reg;
    logic [FILT_W-1:0] filter_next;
    logic              loaded_reg;

    mid_t              mid_reg;
    mid_t              mid_next;
    logic              mid_valid_reg;

    logic              mid_free;
    logic              adv;
    logic              take;

    logic [FILT_W-1:0] s_val;
    logic [FILT_W:0]   up_diff;
    logic [FILT_W-1:0] down_diff;
    logic              rising;
    logic [FILT_W-1:0] mag;
    logic [GAIN_W-1:0] gain;
    logic [PROD_W-1:0] prod;
    logic [FILT_W-1:0] step;
    logic              reject;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    assign mid_free      = !mid_valid_reg || mid_ready;
    assign adv           = in_valid_reg && mid_free;
    assign samples.ready = !in_valid_reg || mid_free;
    assign take          = samples.valid && samples.ready;

    // One shared multiplier serves both directions; the borrow picks the side.
    assign s_val     = {in_sample_reg, {FRAC_BITS{1'b0}}};
    assign up_diff   = {1'b0, s_val} - {1'b0, filter_reg};
    assign down_diff = filter_reg - s_val;
    assign rising    = !up_diff[FILT_W] && (up_diff[FILT_W-1:0] != '0);
    assign mag       = rising ? up_diff[FILT_W-1:0] : down_diff;
    assign gain      = rising ? sat_gain(cfg.rise_gain_q8) : sat_gain(cfg.fall_gain_q8);
    assign prod      = PROD_W'(mag) * PROD_W'(gain);
    assign step      = prod[FILT_W+GAIN_SHIFT-1:GAIN_SHIFT];
    assign reject    = !rising && (down_diff > {cfg.drop_reject_mv, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        filter_next       = filter_reg;
        mid_next.rejected = 1'b0;
        mid_next.check    = 1'b0;
        if (!in_ext_reg)
        begin
            if (!loaded_reg)
            begin
                filter_next = s_val;
            end
            else
            begin
                mid_next.check = 1'b1;
                if (rising)
                begin
                    filter_next = filter_reg + step;
                end
                else if (reject)
                begin
                    mid_next.rejected = 1'b1;
                end
                else
                begin
                    filter_next = filter_reg - step;
                end
            end
        end
        mid_next.filtered_mv = filter_next[FILT_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            filter_reg    <= '0;
            loaded_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                mid_valid_reg <= 1'b1;
                filter_reg    <= filter_next;
                if (!in_ext_reg)
                begin
                    loaded_reg <= 1'b1;
                end
            end
            else if (mid_ready)
            begin
                mid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_sample_reg <= samples.sample_mv;
            in_ext_reg    <= samples.external_power;
        end
        if (adv)
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid       = mid_reg;
    assign mid_valid = mid_valid_reg;

    // A spike can only be rejected once the filter holds a value.
    a_reject_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && mid_reg.rejected |-> mid_reg.check && loaded_reg)
        else $error("rejected beat without a loaded filter");

    // A beat taken under external power leaves the filter untouched.
    a_ext_holds: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_ext_reg |=> $stable(filter_reg) && !mid_reg.check)
        else $error("filter moved under external power");

    // The value handed on always matches the filter state it came from.
    a_mid_tracks_filter: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg |-> mid_reg.filtered_mv == filter_reg[FILT_W-1:FRAC_BITS])
        else $error("filtered value out of step with the filter state");

endmodule

// ===== rtl/bvflm_monitor.sv =====
module bvflm_monitor import bvflm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mid_t       mid,
    input  logic       mid_valid,
    output logic       mid_ready,
    input  cfg_t       cfg,
    bvflm_out_if.source results
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             sleep_reg;
    logic             sleep_next;

    logic             out_valid_reg;
    logic [MV_W-1:0]  out_mv_reg;
    logic             out_rej_reg;

    logic             adv;
    logic             low;

    assign mid_ready = !out_valid_reg || results.ready;
    assign adv       = mid_valid && mid_ready;
    assign low       = mid.filtered_mv < cfg.low_threshold_mv;

    always_comb
    begin
        cnt_next   = cnt_reg;
        sleep_next = sleep_reg;
        if (mid.check)
        begin
            if (low && (cnt_reg != CNT_MAX))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (cnt_next > cfg.low_count_limit)
            begin
                sleep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sleep_reg     <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                sleep_reg     <= sleep_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_mv_reg  <= mid.filtered_mv;
            out_rej_reg <= mid.rejected;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.filtered_mv     = out_mv_reg;
    assign results.sample_rejected = out_rej_reg;
    assign results.low_events      = cnt_reg;
    assign results.sleep_request   = sleep_reg;

    a_sleep_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sleep_reg |=> sleep_reg)
        else $error("sleep request dropped");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("low counter moved by more than one");

    a_count_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cnt_reg) && $stable(sleep_reg))
        else $error("monitor state changed without a beat");

endmodule

// ===== rtl/battery_voltage_filter_low_monitor.sv =====
// Battery voltage filter with low-battery monitor.
// samples (sink): one beat per check period carrying sample_mv and external_power.
// results (source): one beat per sample with filtered_mv, sample_rejected,
//   low_events and sleep_request.
// cfg_we/cfg_index/cfg_data write the gains, reject margin, low threshold and
//   count limit; write them only while no sample is in flight.
// A sample taken from samples is registered at the input, then in the filter
//   stage register, then in the result register that drives results.valid.
// Throughput: one sample per cycle while results.ready stays high. The filter
//   update (one 21x9 multiply with its add) is a loop through the filter
//   register, and the low counter forms the same kind of loop in the monitor stage.
// Reset clears the filter, its loaded flag, the low counter and the sleep
//   request, and restores the register defaults.
// When results.ready is low the result beat is held; the two stages ahead of
//   it still fill, after which samples.ready drops until the receiver takes it.
module battery_voltage_filter_low_monitor import bvflm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bvflm_in_if.sink              samples,
    bvflm_out_if.source           results
);

    cfg_t cfg_reg;
    mid_t mid;
    logic mid_valid;
    logic mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_gain_q8     <= RISE_GAIN_RST;
            cfg_reg.fall_gain_q8     <= FALL_GAIN_RST;
            cfg_reg.drop_reject_mv   <= DROP_REJECT_RST;
            cfg_reg.low_threshold_mv <= LOW_THRESHOLD_RST;
            cfg_reg.low_count_limit  <= LOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RISE_GAIN:     cfg_reg.rise_gain_q8     <= cfg_data[GAIN_W-1:0];
                CFG_FALL_GAIN:     cfg_reg.fall_gain_q8     <= cfg_data[GAIN_W-1:0];
                CFG_DROP_REJECT:   cfg_reg.drop_reject_mv   <= cfg_data[MV_W-1:0];
                CFG_LOW_THRESHOLD: cfg_reg.low_threshold_mv <= cfg_data[MV_W-1:0];
                CFG_LOW_LIMIT:     cfg_reg.low_count_limit  <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    bvflm_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg_reg),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready)
    );

    bvflm_monitor u_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (mid),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .cfg       (cfg_reg),
        .results   (results)
    );

endmodule

// ===== test/tb_battery_voltage_filter_low_monitor.sv =====
module tb_battery_voltage_filter_low_monitor import bvflm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_NUM_REGS   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 500;
    localparam int MV_TOP         = (1 << MV_W) - 1;

    typedef struct packed {
        logic [MV_W-1:0]  filtered_mv;
        logic             sample_rejected;
        logic [CNT_W-1:0] low_events;
        logic             sleep_request;
    } reading_t;

    class voltage_tracker;
        cfg_t              regs;
        logic [FILT_W-1:0] filter_q;
        bit                loaded;
        logic [CNT_W-1:0]  low_cnt;
        bit                sleep;
        reading_t          expected_readings[$];
        int                errors;

        function new();
            regs.rise_gain_q8     = RISE_GAIN_RST;
            regs.fall_gain_q8     = FALL_GAIN_RST;
            regs.drop_reject_mv   = DROP_REJECT_RST;
            regs.low_threshold_mv = LOW_THRESHOLD_RST;
            regs.low_count_limit  = LOW_LIMIT_RST;
            filter_q = '0;
            loaded   = 0;
            low_cnt  = '0;
            sleep    = 0;
            errors   = 0;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RISE_GAIN:     regs.rise_gain_q8     = data[GAIN_W-1:0];
                CFG_FALL_GAIN:     regs.fall_gain_q8     = data[GAIN_W-1:0];
                CFG_DROP_REJECT:   regs.drop_reject_mv   = data[MV_W-1:0];
                CFG_LOW_THRESHOLD: regs.low_threshold_mv = data[MV_W-1:0];
                CFG_LOW_LIMIT:     regs.low_count_limit  = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [GAIN_W-1:0] clip_gain(logic [GAIN_W-1:0] g);
            return (g > GAIN_ONE) ? GAIN_ONE : g;
        endfunction

        function int filtered_now();
            return int'(filter_q[FILT_W-1:FRAC_BITS]);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advances the filter and monitor state by one accepted sample beat.
        function void take_sample(logic [MV_W-1:0] mv, logic ext);
            logic [FILT_W-1:0] scaled;
            logic [FILT_W-1:0] gap;
            logic [PROD_W-1:0] prod;
            reading_t          r;
            r.sample_rejected = 1'b0;
            if (!ext) begin
                scaled = {mv, {FRAC_BITS{1'b0}}};
                if (!loaded) begin
                    filter_q = scaled;
                    loaded   = 1;
                end
                else begin
                    if (scaled > filter_q) begin
                        gap      = scaled - filter_q;
                        prod     = PROD_W'(gap) * PROD_W'(clip_gain(regs.rise_gain_q8));
                        filter_q = filter_q + FILT_W'(prod >> GAIN_SHIFT);
                    end
                    else begin
                        gap = filter_q - scaled;
                        if (gap > {regs.drop_reject_mv, {FRAC_BITS{1'b0}}})
                            r.sample_rejected = 1'b1;
                        else begin
                            prod     = PROD_W'(gap) * PROD_W'(clip_gain(regs.fall_gain_q8));
                            filter_q = filter_q - FILT_W'(prod >> GAIN_SHIFT);
                        end
                    end
                    if (filter_q < {regs.low_threshold_mv, {FRAC_BITS{1'b0}}}
                        && low_cnt != CNT_MAX)
                        low_cnt++;
                    if (low_cnt > regs.low_count_limit)
                        sleep = 1;
                end
            end
            r.filtered_mv   = filter_q[FILT_W-1:FRAC_BITS];
            r.low_events    = low_cnt;
            r.sleep_request = sleep;
            expected_readings.push_back(r);
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0) begin
                complain($sformatf("result beat with nothing expected: mv=%0d rej=%0d cnt=%0d slp=%0d",
                         got.filtered_mv, got.sample_rejected, got.low_events,
                         got.sleep_request));
                return;
            end
            want = expected_readings.pop_front();
            if (got.filtered_mv !== want.filtered_mv
                || got.sample_rejected !== want.sample_rejected
                || got.low_events !== want.low_events
                || got.sleep_request !== want.sleep_request)
                complain($sformatf({"mismatch at %0t: expected mv=%0d rej=%0d cnt=%0d slp=%0d,",
                                    " got mv=%0d rej=%0d cnt=%0d slp=%0d"}, $time,
                         want.filtered_mv, want.sample_rejected, want.low_events,
                         want.sleep_request, got.filtered_mv, got.sample_rejected,
                         got.low_events, got.sleep_request));
        endfunction

        function void close_out();
            if (expected_readings.size() != 0)
                complain($sformatf("%0d result beats never arrived", expected_readings.size()));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bvflm_in_if  samples();
    bvflm_out_if results();

    battery_voltage_filter_low_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .results   (results)
    );

    voltage_tracker tracker;
    int             send_idle_pct;
    int             recv_stall_pct;
    bit             hold_req;
    int             hold_left;
    int             quiet_cycles;
    int             walk_mv;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, plus one long hold-off so that the pipeline
    // fills and the input side stalls.
    initial
    begin
        results.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        reading_t got;
        if (rst_n && results.valid && results.ready)
        begin
            got.filtered_mv     = results.filtered_mv;
            got.sample_rejected = results.sample_rejected;
            got.low_events      = results.low_events;
            got.sleep_request   = results.sleep_request;
            tracker.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int clamp_mv(int v);
        return (v < 0) ? 0 : ((v > MV_TOP) ? MV_TOP : v);
    endfunction

    // All driving tasks start and end just after a falling edge.
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic ext);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid          <= 1'b1;
        samples.sample_mv      <= mv;
        samples.external_power <= ext;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        tracker.take_sample(mv, ext);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.apply_write(idx, data);
        @(negedge clk);
    endtask

    task automatic set_regs(input logic [GAIN_W-1:0] rise, input logic [GAIN_W-1:0] fall,
                            input logic [MV_W-1:0] reject, input logic [MV_W-1:0] thr,
                            input logic [CNT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] data;
        // A write to an unused index must leave every register alone.
        cfg_write(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = rise;
        cfg_write(CFG_RISE_GAIN, data);
        data = CFG_DATA_W'($urandom);
        data[GAIN_W-1:0] = fall;
        cfg_write(CFG_FALL_GAIN, data);
        cfg_write(CFG_DROP_REJECT, reject);
        cfg_write(CFG_LOW_THRESHOLD, thr);
        data = CFG_DATA_W'($urandom);
        data[CNT_W-1:0] = limit;
        cfg_write(CFG_LOW_LIMIT, data);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        samples.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly a slow random walk of the supply with a little noise, which the
    // filter can follow; the rest are external-power beats and wild spikes.
    task automatic run_phase(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                walk_mv = $urandom_range(MV_TOP);
            walk_mv = clamp_mv(walk_mv + $urandom_range(300) - 150);
            if (pick < 10)
                send_sample(MV_W'($urandom), 1'b1);
            else if (pick < 18)
                send_sample(MV_W'($urandom), 1'b0);
            else
                send_sample(MV_W'(clamp_mv(walk_mv + $urandom_range(40) - 20)), 1'b0);
        end
    endtask

    initial
    begin
        tracker                = new();
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        samples.valid          = 1'b0;
        samples.sample_mv      = '0;
        samples.external_power = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        hold_req               = 0;
        quiet_cycles           = 0;
        walk_mv                = 1500;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults: external power before the first load, the load,
        // a fast rise, a spike and small drops around the reject margin.
        send_sample(MV_W'(MV_TOP), 1'b1);
        send_sample(MV_W'(1000), 1'b0);
        send_sample(MV_W'(MV_TOP), 1'b0);
        send_sample(MV_W'(MV_TOP), 1'b0);
        send_sample(MV_W'(0), 1'b0);
        send_sample(MV_W'(tracker.filtered_now() - 50), 1'b0);
        send_sample(MV_W'(tracker.filtered_now() - 100), 1'b0);
        send_sample(MV_W'(tracker.filtered_now() - 99), 1'b0);
        send_sample(MV_W'(0), 1'b1);

        // Full gains, one of them above unity, and nothing treated as a spike.
        settle();
        set_regs(GAIN_ONE, GAIN_W'(511), MV_W'(MV_TOP), MV_W'(MV_TOP), CNT_MAX);
        send_sample(MV_W'(MV_TOP), 1'b0);
        send_sample(MV_W'(0), 1'b0);
        send_sample(MV_W'(0), 1'b0);
        send_sample(MV_W'(MV_TOP), 1'b0);
        send_sample(MV_W'(MV_TOP), 1'b1);
        send_sample(MV_W'(1), 1'b0);

        settle();
        set_regs(GAIN_W'($urandom_range(256)), GAIN_W'($urandom_range(256)),
                 MV_W'($urandom_range(20, 600)), MV_W'(3000), CNT_MAX);
        run_phase(PHASE_ITEMS);

        settle();
        send_idle_pct = 54;
        set_regs(GAIN_W'(0), GAIN_ONE, MV_W'($urandom_range(30, 400)), MV_W'(0), CNT_MAX);
        run_phase(PHASE_ITEMS);

        // Almost every step is low here, so the counter saturates without sleep.
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        set_regs(GAIN_W'(511), GAIN_W'(0), MV_W'(0), MV_W'(MV_TOP), CNT_MAX);
        hold_req = 1;
        run_phase(PHASE_ITEMS);

        settle();
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        set_regs(GAIN_W'($urandom_range(511)), GAIN_W'($urandom_range(511)),
                 MV_W'($urandom_range(MV_TOP)), MV_W'($urandom_range(MV_TOP)), CNT_W'(0));
        run_phase(PHASE_ITEMS);

        settle();
        tracker.close_out();
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
